[rtl/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// Shared constants, codes and controller/datapath interface types for the
// accumulator machine step engine.
// ----------------------------------------------------------------------------
package acs_pkg;

    localparam int MEM_BYTES_DEF = 4096;
    localparam int ADDR_W        = 12;
    localparam int LOADER_LEN    = 56;

    localparam logic [7:0] LOADER_IMAGE [LOADER_LEN] = '{
        8'hc1, 8'h91, 8'h00, 8'hc1, 8'h91, 8'h01, 8'hc1, 8'h91, 8'h02, 8'h81, 8'h00, 8'h40,
        8'h36, 8'h90, 8'h14, 8'h81, 8'h01, 8'h90, 8'h15, 8'hc1, 8'h90, 8'h00, 8'h81, 8'h01,
        8'h40, 8'h35, 8'h91, 8'h01, 8'h81, 8'h02, 8'h50, 8'h35, 8'h91, 8'h02, 8'h10, 8'h34,
        8'h00, 8'h09, 8'h81, 8'h00, 8'h40, 8'h36, 8'h90, 8'h32, 8'h81, 8'h01, 8'h90, 8'h32,
        8'h80, 8'h37, 8'h90, 8'h00, 8'hb1, 8'h01, 8'h90, 8'hb2
    };

    // opcode high nibble
    localparam logic [3:0] OP_JMP   = 4'h0;
    localparam logic [3:0] OP_JZ    = 4'h1;
    localparam logic [3:0] OP_JN    = 4'h2;
    localparam logic [3:0] OP_NOP   = 4'h3;
    localparam logic [3:0] OP_ADD   = 4'h4;
    localparam logic [3:0] OP_SUB   = 4'h5;
    localparam logic [3:0] OP_MUL   = 4'h6;
    localparam logic [3:0] OP_DIV   = 4'h7;
    localparam logic [3:0] OP_LOAD  = 4'h8;
    localparam logic [3:0] OP_STORE = 4'h9;
    localparam logic [3:0] OP_CALL  = 4'ha;
    localparam logic [3:0] OP_SYS   = 4'hb;
    localparam logic [3:0] OP_IO    = 4'hc;

    // low nibble sub-codes
    localparam logic [3:0] SYS_RESTART = 4'h1;
    localparam logic [3:0] SYS_HALT    = 4'h2;
    localparam logic [3:0] IO_READ     = 4'h1;
    localparam logic [3:0] IO_KEY      = 4'h3;
    localparam logic [3:0] IO_PRINT    = 4'h4;
    localparam logic [3:0] IO_NEWLINE  = 4'h5;

    // run status
    localparam logic [2:0] RS_RUN     = 3'd0;
    localparam logic [2:0] RS_HALT    = 3'd1;
    localparam logic [2:0] RS_KEYERR  = 3'd2;
    localparam logic [2:0] RS_ADDR    = 3'd3;
    localparam logic [2:0] RS_DIVZ    = 3'd4;
    localparam logic [2:0] RS_ILLEGAL = 3'd5;

    // output kind
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_NL   = 2'd2;

    // finish commands
    localparam logic [1:0] FIN_NONE = 2'd0;
    localparam logic [1:0] FIN_KEEP = 2'd1;
    localparam logic [1:0] FIN_STOP = 2'd2;
    localparam logic [1:0] FIN_EXEC = 2'd3;

    // memory address select
    localparam logic [1:0] RA_PC   = 2'd0;
    localparam logic [1:0] RA_PC1  = 2'd1;
    localparam logic [1:0] RA_ADDR = 2'd2;
    localparam logic [1:0] RA_CLR  = 2'd3;

    // register map
    localparam logic [2:0] REG_START_ADDR = 3'd0;

    typedef struct packed {
        logic       latch_in;
        logic       latch_op;
        logic       use_rd_op;
        logic [1:0] ram_sel;
        logic       ram_we;
        logic       clr_step;
        logic       div_start;
        logic       div_step;
        logic [1:0] fin;
        logic [2:0] fin_status;
        logic       fin_took;
        logic       load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic       stopped;
        logic       pc_ovf;
        logic       pc1_ovf;
        logic       addr_ovf;
        logic [3:0] rd_hi;
        logic [3:0] rd_lo;
        logic [3:0] op_hi;
        logic       in_ok;
        logic       rd_zero;
        logic       div_done;
        logic       clr_last;
        logic [2:0] stop_code;
    } dp_stat_t;

endpackage

[rtl/acs_ram.sv]
// ----------------------------------------------------------------------------
// acs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module acs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/acs_ctrl.sv]
// ----------------------------------------------------------------------------
// acs_ctrl
// Sequencer for one instruction: fetch, operand, divide, finish, result; clears memory after reset.
// ----------------------------------------------------------------------------
module acs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  acs_pkg::dp_stat_t st,
    output acs_pkg::ctl_cmd_t cmd
);
    import acs_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_OP    = 3'd2;
    localparam logic [2:0] S_ADR   = 3'd3;
    localparam logic [2:0] S_OPND  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.ram_sel  = RA_CLR;
                cmd.ram_we   = 1'b1;
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.ram_sel = RA_PC;
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    if (st.stopped)
                    begin
                        cmd.fin    = FIN_KEEP;
                        state_next = S_DONE;
                    end
                    else if (st.pc_ovf)
                    begin
                        cmd.fin        = FIN_STOP;
                        cmd.fin_status = RS_ADDR;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_OP;
                    end
                end
            end
            S_OP:
            begin
                cmd.latch_op  = 1'b1;
                cmd.use_rd_op = 1'b1;
                cmd.ram_sel   = RA_PC1;
                state_next    = S_DONE;
                case (st.rd_hi) inside
                    OP_NOP:
                    begin
                        cmd.fin = FIN_EXEC;
                    end
                    OP_SYS:
                    begin
                        if (st.rd_lo == SYS_RESTART)
                        begin
                            cmd.fin = FIN_EXEC;
                        end
                        else if (st.rd_lo == SYS_HALT)
                        begin
                            cmd.fin        = FIN_STOP;
                            cmd.fin_status = RS_HALT;
                        end
                        else
                        begin
                            cmd.fin        = FIN_STOP;
                            cmd.fin_status = RS_ILLEGAL;
                        end
                    end
                    OP_IO:
                    begin
                        if (st.rd_lo == IO_KEY && !st.in_ok)
                        begin
                            cmd.fin        = FIN_STOP;
                            cmd.fin_status = RS_KEYERR;
                            cmd.fin_took   = 1'b1;
                        end
                        else
                        begin
                            cmd.fin = FIN_EXEC;
                        end
                    end
                    OP_JMP, OP_JZ, OP_JN, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LOAD,
                    OP_STORE, OP_CALL:
                    begin
                        if (st.pc1_ovf)
                        begin
                            cmd.fin        = FIN_STOP;
                            cmd.fin_status = RS_ADDR;
                        end
                        else
                        begin
                            state_next = S_ADR;
                        end
                    end
                    default:
                    begin
                        cmd.fin        = FIN_STOP;
                        cmd.fin_status = RS_ILLEGAL;
                    end
                endcase
            end
            S_ADR:
            begin
                cmd.ram_sel = RA_ADDR;
                state_next  = S_DONE;
                case (st.op_hi) inside
                    OP_JMP, OP_JZ, OP_JN, OP_CALL:
                    begin
                        cmd.fin = FIN_EXEC;
                    end
                    default:
                    begin
                        if (st.addr_ovf)
                        begin
                            cmd.fin        = FIN_STOP;
                            cmd.fin_status = RS_ADDR;
                        end
                        else if (st.op_hi == OP_STORE)
                        begin
                            cmd.ram_we = 1'b1;
                            cmd.fin    = FIN_EXEC;
                        end
                        else
                        begin
                            state_next = S_OPND;
                        end
                    end
                endcase
            end
            S_OPND:
            begin
                state_next = S_DONE;
                if (st.op_hi == OP_DIV)
                begin
                    if (st.rd_zero)
                    begin
                        cmd.fin        = FIN_STOP;
                        cmd.fin_status = RS_DIVZ;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    cmd.fin = FIN_EXEC;
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    cmd.fin    = FIN_EXEC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[rtl/acs_dpath.sv]
// ----------------------------------------------------------------------------
// acs_dpath
// Machine state, main memory, divider and result register.
// ----------------------------------------------------------------------------
module acs_dpath #(
    parameter int MEM_BYTES = acs_pkg::MEM_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  acs_pkg::ctl_cmd_t          cmd,
    output acs_pkg::dp_stat_t          st,
    input  logic [7:0]                 in_data,
    input  logic                       in_ok,
    input  logic                       cfg_we,
    input  logic [acs_pkg::ADDR_W-1:0] cfg_data,
    output logic [acs_pkg::ADDR_W-1:0] start_addr,
    output logic [31:0]                out_data,
    output logic [1:0]                 out_user
);
    import acs_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [ADDR_W:0] MEM_LIM = (ADDR_W+1)'(MEM_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);
    localparam logic [AW-1:0] LOADER_END = AW'(LOADER_LEN);

    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [7:0]        acc_reg, acc_next;
    logic [2:0]        stop_reg, stop_next;
    logic [ADDR_W-1:0] start_reg;
    logic [AW-1:0]     clr_reg;
    logic [7:0]        op_reg;
    logic [7:0]        in_data_reg;
    logic              in_ok_reg;
    logic [1:0]        kind_reg, kind_next;
    logic              took_reg, took_next;
    logic [7:0]        div_q_reg, div_r_reg, div_m_reg;
    logic [3:0]        div_cnt_reg;
    logic [31:0]       out_data_reg;
    logic [1:0]        out_user_reg;

    logic [7:0]        rd_data;
    logic [7:0]        op_now;
    logic [3:0]        hi, lo;
    logic [ADDR_W:0]   pc1, pc2, npc, addr_ext;
    logic [ADDR_W-1:0] addr12;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_wdata;
    logic [15:0]       mul16;
    logic [8:0]        rem9;
    logic [7:0]        acc_exec;

    assign pc1      = {1'b0, pc_reg} + (ADDR_W+1)'(1);
    assign pc2      = {1'b0, pc_reg} + (ADDR_W+1)'(2);
    assign addr12   = {op_reg[3:0], rd_data};
    assign addr_ext = {1'b0, addr12};

    always_comb
    begin
        case (cmd.ram_sel)
            RA_PC:   ram_addr = pc_reg[AW-1:0];
            RA_PC1:  ram_addr = pc1[AW-1:0];
            RA_ADDR: ram_addr = addr12[AW-1:0];
            default: ram_addr = clr_reg;
        endcase
        if (cmd.ram_sel == RA_CLR)
        begin
            ram_wdata = (clr_reg < LOADER_END) ? LOADER_IMAGE[clr_reg[5:0]] : 8'h00;
        end
        else
        begin
            ram_wdata = acc_reg;
        end
    end

    acs_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd_data)
    );

    // instruction execution
    assign op_now = cmd.use_rd_op ? rd_data : op_reg;
    assign hi     = op_now[7:4];
    assign lo     = op_now[3:0];
    assign mul16  = {8'h00, acc_reg} * {8'h00, rd_data};

    always_comb
    begin
        npc       = pc2;
        acc_exec  = acc_reg;
        kind_next = KIND_NONE;
        took_next = 1'b0;
        case (hi)
            OP_JMP, OP_CALL: npc = addr_ext;
            OP_JZ:
            begin
                if (acc_reg == 8'h00)
                begin
                    npc = addr_ext;
                end
            end
            OP_JN:
            begin
                if (acc_reg[7])
                begin
                    npc = addr_ext;
                end
            end
            OP_NOP:   npc = pc1;
            OP_ADD:   acc_exec = acc_reg + rd_data;
            OP_SUB:   acc_exec = acc_reg - rd_data;
            OP_MUL:   acc_exec = mul16[7:0];
            OP_DIV:   acc_exec = div_q_reg;
            OP_LOAD:  acc_exec = rd_data;
            OP_STORE: acc_exec = acc_reg;
            OP_SYS:   npc = {1'b0, start_reg};
            OP_IO:
            begin
                npc = pc1;
                if (lo == IO_READ || lo == IO_KEY)
                begin
                    acc_exec  = in_data_reg;
                    took_next = 1'b1;
                end
                else if (lo == IO_PRINT)
                begin
                    kind_next = KIND_BYTE;
                end
                else if (lo == IO_NEWLINE)
                begin
                    kind_next = KIND_NL;
                end
            end
            default: npc = pc2;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        acc_next  = acc_reg;
        stop_next = stop_reg;
        case (cmd.fin)
            FIN_STOP: stop_next = cmd.fin_status;
            FIN_EXEC:
            begin
                pc_next   = npc[ADDR_W-1:0];
                acc_next  = acc_exec;
                stop_next = (npc >= MEM_LIM) ? RS_ADDR : RS_RUN;
            end
            default: stop_next = stop_reg;
        endcase
    end

    assign rem9 = {div_r_reg, div_q_reg[7]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            acc_reg   <= '0;
            stop_reg  <= RS_RUN;
            start_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            pc_reg   <= pc_next;
            acc_reg  <= acc_next;
            stop_reg <= stop_next;
            if (cfg_we)
            begin
                start_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_data_reg <= in_data;
            in_ok_reg   <= in_ok;
        end
        if (cmd.latch_op)
        begin
            op_reg <= rd_data;
        end
        if (cmd.fin == FIN_EXEC)
        begin
            kind_reg <= kind_next;
            took_reg <= took_next;
        end
        else if (cmd.fin != FIN_NONE)
        begin
            kind_reg <= KIND_NONE;
            took_reg <= cmd.fin_took;
        end
        if (cmd.div_start)
        begin
            div_q_reg   <= acc_reg;
            div_r_reg   <= 8'h00;
            div_m_reg   <= rd_data;
            div_cnt_reg <= 4'd0;
        end
        else if (cmd.div_step)
        begin
            if (rem9 >= {1'b0, div_m_reg})
            begin
                div_r_reg <= 8'(rem9 - {1'b0, div_m_reg});
                div_q_reg <= {div_q_reg[6:0], 1'b1};
            end
            else
            begin
                div_r_reg <= rem9[7:0];
                div_q_reg <= {div_q_reg[6:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 4'd1;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {stop_reg, took_reg,
                             (kind_reg == KIND_BYTE) ? acc_reg : 8'h00, acc_reg, pc_reg};
            out_user_reg <= kind_reg;
        end
    end

    assign st.stopped   = (stop_reg != RS_RUN);
    assign st.pc_ovf    = ({1'b0, pc_reg} >= MEM_LIM);
    assign st.pc1_ovf   = (pc1 >= MEM_LIM);
    assign st.addr_ovf  = (addr_ext >= MEM_LIM);
    assign st.rd_hi     = rd_data[7:4];
    assign st.rd_lo     = rd_data[3:0];
    assign st.op_hi     = op_reg[7:4];
    assign st.in_ok     = in_ok_reg;
    assign st.rd_zero   = (rd_data == 8'h00);
    assign st.div_done  = (div_cnt_reg == 4'd8);
    assign st.clr_last  = (clr_reg == CLR_LAST);
    assign st.stop_code = stop_reg;

    assign start_addr = start_reg;
    assign out_data   = out_data_reg;
    assign out_user   = out_user_reg;

endmodule

[rtl/accumulator_cpu_step.sv]
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// One instruction of an 8-bit accumulator machine with a MEM_BYTES-byte memory
// (4096 by default) per input item; one result item per instruction.
//
// channel  dir  fields
// s_*      in   tdata[7:0] data_byte; tuser[0] data_ok
// m_*      out  tdata next_pc, acc_value, out_byte, took_input, run_status;
//               tuser[1:0] out_kind
// apb      in   start_address at byte address 0
//
// steps: idle, then result when stopped; one-byte instructions add an opcode
// state, jumps and store an address state, memory operands an operand state,
// divide the bit-serial divider; set by the single registered-read memory port
// reset: after reset every memory byte is written, the boot image then zeros,
// during which no item is taken (configuration writes still work)
// stalls: the result register holds while m_tready is low; the next item is
// taken meanwhile and waits in its final state
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
    parameter int MEM_BYTES = acs_pkg::MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] data_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] next_pc, [19:12] acc_value,
                                   // [27:20] out_byte, [28] took_input,
                                   // [31:29] run_status
    output logic [1:0]  m_tuser,   // [1:0] out_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import acs_pkg::*;

    ctl_cmd_t          cmd;
    dp_stat_t          st;
    logic              cfg_we;
    logic [ADDR_W-1:0] start_addr;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_START_ADDR);
    assign prdata = (paddr == REG_START_ADDR) ? {20'h00000, start_addr} : 32'h0;

    acs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    acs_dpath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .in_data    (s_tdata),
        .in_ok      (s_tuser),
        .cfg_we     (cfg_we),
        .cfg_data   (pwdata[ADDR_W-1:0]),
        .start_addr (start_addr),
        .out_data   (m_tdata),
        .out_user   (m_tuser)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous one in progress");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (st.stop_code != RS_RUN) |=> (st.stop_code == $past(st.stop_code)))
        else $error("stop code changed after machine stopped");

    a_print_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_BYTE) |-> (m_tdata[27:20] == m_tdata[19:12]))
        else $error("printed byte differs from accumulator");

endmodule
